// ----- src/isq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_pkg
// Shared sizes, command and status codes and state type of the indexed
// sequence store.
// ----------------------------------------------------------------------------
package isq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_AT   = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT
  } state_t;

endpackage

// ----- src/isq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module isq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/indexed_sequence_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of up to CAPACITY signed 32-bit entries held in one RAM.
// ----------------------------------------------------------------------------
// Usage: raise start with in_command, in_position and in_data_in while busy
// is low; the item is taken at that clock edge. Every item gives exactly one
// result on out_status, out_read_data and out_entry_count, marked by
// out_valid for a single cycle; the receiver cannot hold it off.
// Path from the accepting edge to out_valid:
//   rejected or unknown command: result registered at the accepting edge,
//   read: ST_READ with one RAM read, then the result register,
//   insert: ST_SHIFT moves the later entries up, then writes the new one,
//   delete: ST_SHIFT moves the later entries down, then lowers the count.
// Inserts and deletes move every later entry by one place, one entry per
// cycle, through the single RAM read port and write port; that shift loop
// sets the throughput. busy stays high until the result is registered, so a
// new item can be taken in the cycle its predecessor's result is shown.
// Reset empties the store (count zero); entry contents are not cleared since
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_store
  import isq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_command,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_read_data,
  output logic [CNT_W-1:0]         out_entry_count
);

  localparam logic [DATA_W-1:0] NEG_ONE = '1;
  localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 dir_r, dir_nxt;       // 1 insert (shift up), 0 delete
  logic [CNT_W-1:0]     moves_r, moves_nxt;
  logic [ADDR_W-1:0]    src_r, src_nxt;
  logic [ADDR_W-1:0]    dst_r, dst_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [DATA_W-1:0]    data_r, data_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [DATA_W-1:0]    out_read_data_r, out_read_data_nxt;
  logic [CNT_W-1:0]     out_entry_count_r, out_entry_count_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]     ins_pos;
  logic                 is_insert;

  isq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r             <= dir_nxt;
    moves_r           <= moves_nxt;
    src_r             <= src_nxt;
    dst_r             <= dst_nxt;
    pos_r             <= pos_nxt;
    data_r            <= data_nxt;
    out_status_r      <= out_status_nxt;
    out_read_data_r   <= out_read_data_nxt;
    out_entry_count_r <= out_entry_count_nxt;
  end

  always_comb begin
    case (in_command)
      CMD_INS_HEAD: ins_pos = '0;
      CMD_INS_TAIL: ins_pos = count_r;
      default:      ins_pos = in_position;
    endcase
    is_insert = (in_command == CMD_INS_HEAD) || (in_command == CMD_INS_TAIL) ||
                (in_command == CMD_INS_AT);
  end

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    dir_nxt             = dir_r;
    moves_nxt           = moves_r;
    src_nxt             = src_r;
    dst_nxt             = dst_r;
    pend_nxt            = pend_r;
    pos_nxt             = pos_r;
    data_nxt            = data_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_read_data_nxt   = out_read_data_r;
    out_entry_count_nxt = out_entry_count_r;
    ram_we              = 1'b0;
    ram_waddr           = dst_r;
    ram_wdata           = ram_rdata;
    ram_raddr           = src_r;

    case (state_r)
      ST_IDLE: begin
        ram_raddr = in_position[ADDR_W-1:0];
        if (start) begin
          out_status_nxt      = STAT_RANGE;
          out_read_data_nxt   = NEG_ONE;
          out_entry_count_nxt = count_r;
          pend_nxt            = 1'b0;
          data_nxt            = in_data_in;
          if (in_command == CMD_READ) begin
            if (in_position < count_r) begin
              state_nxt = ST_READ;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (is_insert) begin
            if (ins_pos > count_r) begin
              out_valid_nxt = 1'b1;
            end else if (count_r == CAP_CNT) begin
              out_status_nxt = STAT_FULL;
              out_valid_nxt  = 1'b1;
            end else begin
              dir_nxt   = 1'b1;
              moves_nxt = count_r - ins_pos;
              src_nxt   = ADDR_W'(count_r - CNT_W'(1));
              pos_nxt   = ins_pos[ADDR_W-1:0];
              state_nxt = ST_SHIFT;
            end
          end else if (in_command == CMD_DELETE) begin
            if (in_position >= count_r) begin
              out_valid_nxt = 1'b1;
            end else begin
              dir_nxt   = 1'b0;
              moves_nxt = count_r - in_position - CNT_W'(1);
              src_nxt   = ADDR_W'(in_position + POS_W'(1));
              pos_nxt   = in_position[ADDR_W-1:0];
              state_nxt = ST_SHIFT;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt     = 1'b1;
        out_status_nxt    = STAT_DONE;
        out_read_data_nxt = ram_rdata;
        state_nxt         = ST_IDLE;
      end

      ST_SHIFT: begin
        // The word read in the previous cycle lands one place over.
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (moves_r != '0) begin
          ram_raddr = src_r;
          pend_nxt  = 1'b1;
          dst_nxt   = dir_r ? src_r + ADDR_W'(1) : src_r - ADDR_W'(1);
          src_nxt   = dir_r ? src_r - ADDR_W'(1) : src_r + ADDR_W'(1);
          moves_nxt = moves_r - CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          if (dir_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = data_r;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
          out_valid_nxt       = 1'b1;
          out_status_nxt      = STAT_DONE;
          out_read_data_nxt   = NEG_ONE;
          out_entry_count_nxt = count_nxt;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_entry_count = out_entry_count_r;

endmodule
